[rtl/smc_pkg.sv]
// Shared types and constants for the substring match counter.
`default_nettype none

package smc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 2'd2;

  localparam int PLEN_W   = 5;
  localparam int TEXT_W   = 8;
  localparam int FIELD_W  = 16;
  localparam int RES_W    = 40;

  localparam logic [FIELD_W-1:0] COUNT_MAX = '1;

  // Result beat, lowest bit first: found, first_index, match_count,
  // starts_with_pattern, ends_with_pattern, too_long, zero pad.
  typedef struct packed {
    logic [3:0]         pad;
    logic               too_long;
    logic               ends_with_pattern;
    logic               starts_with_pattern;
    logic [FIELD_W-1:0] match_count;
    logic [FIELD_W-1:0] first_index;
    logic               found;
  } res_t;

endpackage

`default_nettype wire

[rtl/substring_match_counter.sv]
// Streaming substring search: first index, non-overlapping count, prefix/suffix flags.
`default_nettype none
// Text bytes enter on the s_axis channel, one byte per beat: tdata carries the
// byte, tuser marks whether the byte is real (low marks an empty string), tlast
// marks the last beat of a string. On the last beat one result beat leaves on
// m_axis: found, first occurrence index, greedy non-overlapping count,
// starts-with and ends-with flags, and a too-long flag once the position
// counter saturates.
// The pattern (length plus up to sixteen bytes) is written through the cfg
// channel, which is always ready; write it only while no string is in flight.
// A beat is captured in an input register and processed from there; the result
// of a string is registered in the output register. Throughput: one text beat
// per cycle while no string end waits on a stalled result; the window compare
// for all pattern positions runs in parallel in the single processing stage.
// The output register holds a result until taken; while it is stalled, text
// beats that do not end a string still flow, and a string end waits in the
// input register, which then backpressures s_axis.
// Reset clears all per-string state and the pattern registers (empty pattern).

module substring_match_counter #(
  parameter int PATTERN_MAX = 16,
  parameter int INDEX_BITS  = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [smc_pkg::TEXT_W-1:0]     s_axis_tdata_i,   // text_byte
  input  logic                           s_axis_tuser_i,   // byte_present
  input  logic                           s_axis_tlast_i,   // string_end
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // found, first_index[15:0], match_count[15:0], starts_with_pattern,
  // ends_with_pattern, too_long, zero pad
  output logic [smc_pkg::RES_W-1:0]      m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [smc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [smc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import smc_pkg::*;

  localparam int LEN_W     = ($clog2(PATTERN_MAX + 1) > PLEN_W) ?
                             $clog2(PATTERN_MAX + 1) : PLEN_W;
  localparam int IDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int PAT_SLOTS = 2 ** IDX_W;

  // Configuration
  logic [PLEN_W-1:0]     plen_q;
  logic [CFG_DATA_W-1:0] pat_lo_q, pat_hi_q;

  // Input register
  logic              s1_valid_q;
  logic [TEXT_W-1:0] s1_byte_q;
  logic              s1_present_q;
  logic              s1_end_q;

  // Per-string state
  logic [TEXT_W-1:0]     win_q [PATTERN_MAX];
  logic [INDEX_BITS-1:0] pos_q, pos_d;
  logic [INDEX_BITS-1:0] first_q, first_d;
  logic                  seen_q, seen_d;
  logic [FIELD_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]      holdoff_q, holdoff_d;
  logic                  prefix_q, prefix_d;
  logic                  ovf_q, ovf_d;

  // Output register
  logic out_valid_q, out_valid_d;
  res_t res_q, res_d;

  logic out_free, s1_fire, res_load;

  logic [LEN_W-1:0]      len_c;
  logic [TEXT_W-1:0]     pat_c [PAT_SLOTS];
  logic [TEXT_W-1:0]     win_c [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] eq_c;
  logic [INDEX_BITS-1:0] pos_inc, pos_c, start_c;
  logic                  ovf_inc, ovf_c, match_c;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q   <= '0;
      pat_lo_q <= '0;
      pat_hi_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PATTERN_LENGTH: plen_q   <= cfg_data_i[PLEN_W-1:0];
        CFG_PATTERN_LOW:    pat_lo_q <= cfg_data_i;
        CFG_PATTERN_HIGH:   pat_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: a string end needs a free output slot to leave the input register
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s1_fire         = s1_valid_q && (!s1_end_q || out_free);
  assign s_axis_tready_o = !s1_valid_q || s1_fire;
  assign res_load        = s1_fire && s1_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      s1_byte_q    <= s_axis_tdata_i;
      s1_present_q <= s_axis_tuser_i;
      s1_end_q     <= s_axis_tlast_i;
    end
  end

  // Active length, clamped to the window size
  always_comb begin
    if (LEN_W'(plen_q) > LEN_W'(PATTERN_MAX)) begin
      len_c = LEN_W'(PATTERN_MAX);
    end else begin
      len_c = LEN_W'(plen_q);
    end
  end

  // Pattern bytes past the two registers read as zero
  for (genvar k = 0; k < PAT_SLOTS; k++) begin : g_pat
    if (k < 8) begin : g_lo
      assign pat_c[k] = pat_lo_q[8*k +: 8];
    end else if (k < 16) begin : g_hi
      assign pat_c[k] = pat_hi_q[8*(k-8) +: 8];
    end else begin : g_zero
      assign pat_c[k] = '0;
    end
  end

  assign pos_inc = (&pos_q) ? pos_q : pos_q + INDEX_BITS'(1);
  assign ovf_inc = ovf_q | (&pos_q);
  assign pos_c   = s1_present_q ? pos_inc : pos_q;
  assign ovf_c   = s1_present_q ? ovf_inc : ovf_q;

  // Window as it stands after this beat; entry 0 is the newest byte
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_win
    logic [LEN_W-1:0] pidx;
    if (i == 0) begin : g_new
      assign win_c[i] = s1_present_q ? s1_byte_q : win_q[i];
    end else begin : g_old
      assign win_c[i] = s1_present_q ? win_q[i-1] : win_q[i];
    end
    assign pidx    = len_c - LEN_W'(i) - LEN_W'(1);
    assign eq_c[i] = (LEN_W'(i) >= len_c) || (win_c[i] == pat_c[pidx[IDX_W-1:0]]);
  end

  assign match_c = (len_c != '0) && (ovf_c || (pos_c >= INDEX_BITS'(len_c))) && (&eq_c);
  assign start_c = ovf_c ? '1 : pos_c - INDEX_BITS'(len_c);

  always_comb begin
    pos_d     = pos_q;
    first_d   = first_q;
    seen_d    = seen_q;
    count_d   = count_q;
    holdoff_d = holdoff_q;
    prefix_d  = prefix_q;
    ovf_d     = ovf_q;
    res_d     = res_q;

    if (s1_fire && s1_present_q) begin
      pos_d = pos_inc;
      ovf_d = ovf_inc;
      if (match_c) begin
        if (!seen_q) begin
          seen_d  = 1'b1;
          first_d = start_c;
        end
        if (!ovf_c && (pos_c == INDEX_BITS'(len_c))) begin
          prefix_d = 1'b1;
        end
        if (holdoff_q == '0) begin
          if (count_q != COUNT_MAX) begin
            count_d = count_q + FIELD_W'(1);
          end
          holdoff_d = IDX_W'(len_c - LEN_W'(1));
        end else begin
          holdoff_d = holdoff_q - IDX_W'(1);
        end
      end else if (holdoff_q != '0) begin
        holdoff_d = holdoff_q - IDX_W'(1);
      end
    end

    if (res_load) begin
      res_d.pad      = '0;
      res_d.too_long = ovf_d;
      if (len_c == '0) begin
        res_d.found               = 1'b1;
        res_d.first_index         = '0;
        res_d.match_count         = '0;
        res_d.starts_with_pattern = 1'b1;
        res_d.ends_with_pattern   = 1'b1;
      end else begin
        res_d.found               = seen_d;
        res_d.first_index         = seen_d ? FIELD_W'(first_d) : '0;
        res_d.match_count         = count_d;
        res_d.starts_with_pattern = prefix_d;
        res_d.ends_with_pattern   = match_c;
      end
      // Drop per-string state for the next string
      pos_d     = '0;
      first_d   = '0;
      seen_d    = 1'b0;
      count_d   = '0;
      holdoff_d = '0;
      prefix_d  = 1'b0;
      ovf_d     = 1'b0;
    end
  end

  always_comb begin
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      first_q     <= '0;
      seen_q      <= 1'b0;
      count_q     <= '0;
      holdoff_q   <= '0;
      prefix_q    <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      first_q     <= first_d;
      seen_q      <= seen_d;
      count_q     <= count_d;
      holdoff_q   <= holdoff_d;
      prefix_q    <= prefix_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Window taps hold bytes only; stale entries are masked by the position check
  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_present_q) begin
      win_q[0] <= s1_byte_q;
      for (int j = 1; j < PATTERN_MAX; j++) begin
        win_q[j] <= win_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = res_q;

  a_no_index_without_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.found) |-> (res_q.first_index == '0))
    else $error("first_index set without a match");

  a_count_implies_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (res_q.match_count != '0)) |-> res_q.found)
    else $error("nonzero count without a match");

  a_prefix_implies_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.starts_with_pattern) |-> res_q.found)
    else $error("starts_with set without a match");

  a_end_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_end_q && !out_free) |=> (s1_valid_q && s1_end_q))
    else $error("string end lost while result stalled");

endmodule

`default_nettype wire
